/* sv/i2a_pkg.sv */
// Package: payload types and constants for the integer to ASCII formatter.
`default_nettype none
package i2a_pkg;
  localparam int unsigned ValueWidthDef = 32;
  localparam int unsigned InWidth = 32;
  localparam logic [7:0] ChrZero = 8'h30;
  localparam logic [7:0] ChrA = 8'h41;
  localparam logic [7:0] ChrMinus = 8'h2D;
  localparam logic FuncDec = 1'b0;
  localparam logic FuncHex = 1'b1;

  typedef struct packed {
    logic               func;
    logic [InWidth-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] ascii_char;
    logic       last;
    logic [3:0] char_count;
  } out_item_t;

  // Map a digit value to its uppercase ASCII code.
  function automatic logic [7:0] digit_chr(input logic [3:0] d);
    logic [7:0] r;
    if (d >= 4'd10) r = ChrA + {4'd0, d - 4'd10};
    else r = ChrZero + {4'd0, d};
    return r;
  endfunction
endpackage
`default_nettype wire

/* sv/i2a_pipe_stage.sv */
// Module: one stage of the digit pipeline; peel one digit of a held word.
`default_nettype none
module i2a_pipe_stage import i2a_pkg::*; #(
  parameter int unsigned MagW = 33,
  parameter int unsigned NChr = 11,
  parameter int unsigned IdxW = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire logic            hex_i,
  input  wire logic [MagW-1:0] mag_i,
  input  wire logic [IdxW-1:0] pos_i,
  input  wire logic [NChr*4-1:0] dig_i,
  output logic                 valid_o,
  output logic                 hex_o,
  output logic [MagW-1:0]      mag_o,
  output logic [NChr*4-1:0]    dig_o
);
  logic [MagW-1:0] quo;
  logic [3:0] rem;
  logic [MagW-1:0] q;
  logic [MagW-1:0] r10;
  logic [NChr*4-1:0] dig_d;

  // Divide by ten with a shift-and-add estimate and one remainder fix, or by sixteen with a shift in hex mode.
  always_comb begin
    q = (mag_i >> 1) + (mag_i >> 2);
    q = q + (q >> 4);
    q = q + (q >> 8);
    q = q + (q >> 16);
    q = q + (q >> 32);
    q = q >> 3;
    r10 = mag_i - ((q << 3) + (q << 1));
    if (hex_i) begin
      quo = mag_i >> 4;
      rem = mag_i[3:0];
    end else if (r10 > MagW'(9)) begin
      quo = q + MagW'(1);
      rem = 4'(r10 - MagW'(10));
    end else begin
      quo = q;
      rem = r10[3:0];
    end
    dig_d = dig_i;
    dig_d[pos_i*4 +: 4] = rem;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hex_o <= hex_i;
      mag_o <= quo;
      dig_o <= dig_d;
    end
  end
endmodule
`default_nettype wire

/* sv/i2a_emit.sv */
// Module: serializer that walks the finished digit row out one character at a time.
`default_nettype none
module i2a_emit import i2a_pkg::*; #(
  parameter int unsigned NChr = 11,
  parameter int unsigned IdxW = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire logic            neg_i,
  input  wire logic [NChr*4-1:0] dig_i,
  output logic                 busy_o,
  input  wire logic            out_stall_i,
  output logic                 out_valid_o,
  output out_item_t            out_data_o
);
  logic [NChr*4-1:0] dig_q;
  logic [IdxW-1:0] cur_q, cur_d, top;
  logic sign_q, sign_d, busy_q, busy_d;
  logic [3:0] cnt_q, cnt_d;
  logic [4:0] tot;

  // Highest nonzero digit sets the count; zero keeps one digit.
  always_comb begin
    top = '0;
    for (int i = 0; i < NChr; i++) begin
      if (dig_i[i*4 +: 4] != 4'd0) top = IdxW'(i);
    end
  end

  assign busy_o = busy_q;
  assign tot = 5'(top) + 5'd1 + {4'd0, neg_i};

  always_comb begin
    busy_d = busy_q;
    cur_d = cur_q;
    sign_d = sign_q;
    cnt_d = cnt_q;
    out_data_o.ascii_char = sign_q ? ChrMinus : digit_chr(dig_q[cur_q*4 +: 4]);
    out_data_o.last = !sign_q && (cur_q == '0);
    out_data_o.char_count = out_data_o.last ? cnt_q : 4'd0;
    if (busy_q && !out_stall_i) begin
      if (sign_q) sign_d = 1'b0;
      else if (cur_q == '0) busy_d = 1'b0;
      else cur_d = cur_q - IdxW'(1);
    end
    if (valid_i && !busy_q) begin
      busy_d = 1'b1;
      cur_d = top;
      sign_d = neg_i;
      cnt_d = tot[3:0];
    end
  end

  assign out_valid_o = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sign_q <= 1'b0;
      cur_q <= '0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      sign_q <= sign_d;
      cur_q <= cur_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !busy_q) begin
      dig_q <= dig_i;
    end
  end
endmodule
`default_nettype wire

/* sv/integer_to_ascii_formatter_core.sv */
// Module: top level of the integer to ASCII formatter.
// Channel | Dir | Handshake           | Payload
// in      | in  | in_valid_i/in_stall_o | in_item_t  (func, value)
// out     | out | out_valid_o/out_stall_i | out_item_t (ascii_char, last, char_count)
// An accepted value runs through an entry stage, one register stage per digit,
// and a serializer; the digit stages advance together when their tail is free.
// The first character shows after the entry register, the digit stages and the emit state.
// The serializer sends one character per cycle unless the output stalls, and takes a new
// value only after the last character of the one before has gone; that port sets the rate.
// Reset clears all valid bits; payload registers keep no reset.
// Stall on the output holds the serializer, which then holds the digit stages.
`default_nettype none
module integer_to_ascii_formatter_core import i2a_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = ValueWidthDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_item_t out_data_o
);
  localparam int unsigned MagW = VALUE_WIDTH + 1;
  localparam int unsigned NChr = (VALUE_WIDTH * 3 + 9) / 10 + 1;
  localparam int unsigned IdxW = $clog2(NChr + 1);

  logic en;
  logic emit_busy;
  logic [VALUE_WIDTH-1:0] v;
  logic is_neg;

  logic [NChr:0] vld;
  logic [NChr:0] hx;
  logic [MagW-1:0] mg [NChr+1];
  logic [NChr*4-1:0] dg [NChr+1];
  logic [NChr:0] ng;
  logic ent_vld_q;
  logic ent_hex_q;
  logic [MagW-1:0] ent_mag_q;
  logic ent_neg_q;

  // Advance the pipe unless its tail holds a value while the serializer is busy.
  assign en = !(vld[NChr] && emit_busy);
  assign in_stall_o = !en;

  // Keep the low operand bits; zero-extend when the operand is narrower than the field.
  assign v = VALUE_WIDTH'(in_data_i.value);
  assign is_neg = (in_data_i.func == FuncDec) && v[VALUE_WIDTH-1];

  // Entry stage: form the magnitude; the most negative value fits in MagW.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= 1'b0;
    end else if (en) begin
      ent_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ent_hex_q <= (in_data_i.func == FuncHex);
      ent_mag_q <= is_neg ? (MagW'(0) - {1'b1, v}) : {1'b0, v};
      ent_neg_q <= is_neg;
    end
  end
  assign vld[0] = ent_vld_q;
  assign hx[0] = ent_hex_q;
  assign mg[0] = ent_mag_q;
  assign dg[0] = '0;
  assign ng[0] = ent_neg_q;

  for (genvar s = 0; s < NChr; s++) begin : g_stage
    logic neg_q;
    i2a_pipe_stage #(.MagW(MagW), .NChr(NChr), .IdxW(IdxW)) u_stage (
      .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
      .valid_i(vld[s]), .hex_i(hx[s]), .mag_i(mg[s]),
      .pos_i(IdxW'(s)), .dig_i(dg[s]),
      .valid_o(vld[s+1]), .hex_o(hx[s+1]), .mag_o(mg[s+1]), .dig_o(dg[s+1])
    );
    // Carry the sign along with its digits.
    always_ff @(posedge clk_i) begin
      if (en) neg_q <= ng[s];
    end
    assign ng[s+1] = neg_q;
  end

  i2a_emit #(.NChr(NChr), .IdxW(IdxW)) u_emit (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .valid_i(vld[NChr]), .neg_i(ng[NChr]), .dig_i(dg[NChr]),
    .busy_o(emit_busy),
    .out_stall_i(out_stall_i), .out_valid_o(out_valid_o), .out_data_o(out_data_o)
  );
endmodule
`default_nettype wire

/* sv/i2a_checker.sv */
// Module: port checker for the formatter, bound to the top level.
`default_nettype none
module i2a_checker import i2a_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input out_item_t out_data_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed under stall");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> out_data_o.char_count == 4'd0)
    else $error("count on a non-final character");
  a_lastcnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last |-> out_data_o.char_count != 4'd0)
    else $error("zero count on final character");
  a_minus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.ascii_char == ChrMinus |-> !out_data_o.last)
    else $error("sign as final character");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with an idle output");
endmodule

bind integer_to_ascii_formatter_core i2a_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
);
`default_nettype wire

/* tb/integer_to_ascii_formatter_core_test.sv */
// Testbench for the integer to ASCII formatter: directed table plus random values, self-checked.
`default_nettype none
module integer_to_ascii_formatter_core_test;
  import i2a_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned NumRandom = 136;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;

  integer_to_ascii_formatter_core u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  // Expected characters, oldest first.
  out_item_t char_queue[$];
  int unsigned mismatches = 0;
  int unsigned row_errors;
  int unsigned cycles = 0;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit hold_off;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Predict the character string for one value and queue it.
  task automatic format_value(input in_item_t item);
    logic [32:0] mag;
    logic [7:0] rev[$];
    logic [3:0] d;
    bit neg;
    int unsigned total;
    int unsigned k;
    out_item_t c;
    neg = 1'b0;
    mag = {1'b0, item.value};
    if (item.func == FuncDec && item.value[31]) begin
      neg = 1'b1;
      // A 33-bit negate gives 2^31 for the most negative value.
      mag = {1'b0, ~item.value} + 33'd1;
    end
    do begin
      if (item.func == FuncHex) begin
        d = mag[3:0];
        mag = mag >> 4;
      end else begin
        d = 4'(mag % 33'd10);
        mag = mag / 33'd10;
      end
      rev.push_back(d >= 4'd10 ? 8'h41 + 8'(d - 4'd10) : 8'h30 + 8'(d));
    end while (mag != 0);
    total = rev.size() + (neg ? 1 : 0);
    k = 0;
    if (neg) begin
      c = '{ascii_char: ChrMinus, last: 1'b0, char_count: 4'd0};
      k = 1;
      if (k == total) begin
        c.last = 1'b1;
        c.char_count = 4'(total);
      end
      char_queue.push_back(c);
    end
    while (rev.size() > 0) begin
      k++;
      c = '{ascii_char: rev.pop_back(), last: 1'b0, char_count: 4'd0};
      if (k == total) begin
        c.last = 1'b1;
        c.char_count = 4'(total);
      end
      char_queue.push_back(c);
    end
  endtask

  // Offer one value, honoring the idle rate; return once it is accepted.
  task automatic send_value(input in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    format_value(item);
    do begin
      @(posedge clk);
    end while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (char_queue.size() > 0) begin
      @(posedge clk);
    end
    repeat (30) @(posedge clk);
  endtask

  // Drive stall at random, or hold it high during a hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Compare every accepted character with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (char_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected char %h last %b count %0d",
                   out_data.ascii_char, out_data.last, out_data.char_count);
        end
      end else begin
        want = char_queue.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: want %h/%b/%0d got %h/%b/%0d",
                     want.ascii_char, want.last, want.char_count,
                     out_data.ascii_char, out_data.last, out_data.char_count);
          end
        end
      end
    end
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Directed rows; expected text typed in where it is obvious.
  typedef struct {
    logic func;
    logic [31:0] value;
    string text;
  } row_t;

  row_t rows[] = '{
    '{FuncDec, 32'h0000_0000, "0"},
    '{FuncHex, 32'h0000_0000, "0"},
    '{FuncDec, 32'h8000_0000, "-2147483648"},
    '{FuncDec, 32'h7FFF_FFFF, "2147483647"},
    '{FuncDec, 32'hFFFF_FFFF, "-1"},
    '{FuncHex, 32'hFFFF_FFFF, "FFFFFFFF"},
    '{FuncHex, 32'h8000_0000, "80000000"},
    '{FuncDec, 32'd9, "9"},
    '{FuncDec, 32'd10, "10"},
    '{FuncHex, 32'h0000_000A, "A"},
    '{FuncHex, 32'h0000_00F0, "F0"},
    '{FuncHex, 32'h1234_5678, "12345678"},
    '{FuncHex, 32'h9ABC_DEF0, "9ABCDEF0"},
    '{FuncDec, 32'hFFFF_FFF6, "-10"},
    '{FuncDec, 32'd1000000000, "1000000000"},
    '{FuncDec, 32'h5555_5555, ""},
    '{FuncDec, 32'hAAAA_AAAA, ""},
    '{FuncHex, 32'h0000_0001, "1"}
  };

  // Check a typed-in row against the predictor before it is sent.
  task automatic check_row(input row_t r);
    out_item_t saved[$];
    string got;
    if (r.text.len() == 0) return;
    saved = char_queue;
    char_queue = {};
    format_value('{func: r.func, value: r.value});
    got = "";
    foreach (char_queue[i]) got = {got, string'(char_queue[i].ascii_char)};
    if (got != r.text) begin
      row_errors++;
      if (row_errors <= 10) $display("table row %s predicted %s", r.text, got);
    end
    char_queue = saved;
  endtask

  initial begin
    in_item_t item;
    int unsigned pick;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    hold_off = 1'b0;
    row_errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      check_row(rows[i]);
      send_value('{func: rows[i].func, value: rows[i].value});
    end
    drain();

    // Pressure: stall the receiver long enough for the input to back up.
    fork
      begin
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
      end
      for (int i = 0; i < 24; i++) begin
        item.func = 1'($urandom);
        item.value = $urandom;
        send_value(item);
      end
    join
    drain();

    // Phases: none, sender idle, receiver stall, both light.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 66 : (ph == 3) ? 6 : 0;
      recv_stall_pct = (ph == 2) ? 66 : (ph == 3) ? 6 : 0;
      for (int i = 0; i < NumRandom / 4; i++) begin
        item.func = 1'($urandom);
        pick = $urandom_range(3);
        case (pick)
          0: item.value = $urandom_range(255);
          1: item.value = $urandom >> $urandom_range(31);
          2: item.value = ~($urandom >> $urandom_range(31));
          default: item.value = $urandom;
        endcase
        send_value(item);
      end
      drain();
    end

    if (mismatches == 0 && row_errors == 0 && char_queue.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
